// ===== rtl/core/ccgs_pkg.sv =====
// Shared constants and the per-step odd-count gate table for the Collatz sieve.
`default_nettype none
package ccgs_pkg;

  localparam int OFFSET_W = 28;
  localparam int VALUE_W  = 64;
  localparam int COUNT_W  = 7;
  localparam int ODD_W    = 6;
  localparam int MAX_STEPS = 64;

  localparam logic [ODD_W-1:0] ODD_SAT = {ODD_W{1'b1}};

  localparam logic [ODD_W-1:0] GATE_MIN [MAX_STEPS] = '{
    6'd1,  6'd2,  6'd2,  6'd3,  6'd4,  6'd4,  6'd5,  6'd6,  6'd6,  6'd7,
    6'd7,  6'd8,  6'd9,  6'd9,  6'd10, 6'd11, 6'd11, 6'd12, 6'd12, 6'd13,
    6'd14, 6'd14, 6'd15, 6'd16, 6'd16, 6'd17, 6'd18, 6'd18, 6'd19, 6'd19,
    6'd20, 6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26,
    6'd26, 6'd27, 6'd28, 6'd28, 6'd29, 6'd30, 6'd30, 6'd31, 6'd31, 6'd32,
    6'd33, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd36, 6'd37, 6'd38, 6'd38,
    6'd39, 6'd40, 6'd40, 6'd41
  };

endpackage
`default_nettype wire

// ===== rtl/core/ccgs_cell.sv =====
// One shortcut Collatz step with its odd-count gate, registered toward the next cell.
`default_nettype none
module ccgs_cell #(
  parameter int K       = 1,
  parameter int VW      = 89,
  parameter int OB      = 28
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         valid_in,
  input  wire logic [OB-1:0]                offset_in,
  input  wire logic [VW-1:0]                value_in,
  input  wire logic [ccgs_pkg::COUNT_W-1:0] count_in,
  output logic                              valid,
  output logic [OB-1:0]                     offset,
  output logic [VW-1:0]                     value,
  output logic [ccgs_pkg::COUNT_W-1:0]      count
);
  import ccgs_pkg::*;

  localparam logic [COUNT_W-1:0] GATE = COUNT_W'(GATE_MIN[K-1]);

  logic                 odd;
  logic [VW-1:0]        value_next;
  logic [COUNT_W-1:0]   count_next;
  logic                 pass;

  assign odd        = value_in[0];
  assign value_next = odd ? (value_in + (value_in >> 1) + VW'(1)) : (value_in >> 1);
  assign count_next = odd ? (count_in + COUNT_W'(1)) : count_in;
  assign pass       = (count_next >= GATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_in & pass;
    end
  end

  always_ff @(posedge clk) begin
    offset <= offset_in;
    value  <= value_next;
    count  <= count_next;
  end

endmodule
`default_nettype wire

// ===== rtl/core/collatz_coefficient_gate_sieve.sv =====
// Top level of the Collatz shortcut sieve: a chain of one cell per step.
//
// Usage: drive offset and raise start for one cycle per item. busy is high only
// while rst is high, so outside reset an item is taken at every edge where start is
// high: one item per cycle.
// Each cell applies one shortcut step (odd n to (3n+1)/2, even n halved) and checks
// the running odd count against that step's gate. An item that misses a gate is
// dropped inside the chain and produces no result.
// A surviving item's result is registered once per step, in every cell of the chain;
// strobe is high for exactly one cycle with offset_echo, end_value and odd_count.
// Throughput is one item per cycle.
// The receiver cannot stall; results are never held.
// Reset (synchronous, rst high) clears every cell's valid flag; items in flight
// are discarded.
`default_nettype none
module collatz_coefficient_gate_sieve #(
  parameter int STEPS       = 61,
  parameter int OFFSET_BITS = 28
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ccgs_pkg::OFFSET_W-1:0] offset,
  output logic                               strobe,
  output logic [ccgs_pkg::OFFSET_W-1:0]      offset_echo,
  output logic [ccgs_pkg::VALUE_W-1:0]       end_value,
  output logic [ccgs_pkg::ODD_W-1:0]         odd_count
);
  import ccgs_pkg::*;

  localparam int VW = OFFSET_BITS + STEPS;

  logic                 valid_s  [STEPS+1];
  logic [OFFSET_BITS-1:0] offset_s [STEPS+1];
  logic [VW-1:0]        value_s  [STEPS+1];
  logic [COUNT_W-1:0]   count_s  [STEPS+1];

  logic [VW+VALUE_W-1:0] value_ext;

  assign busy        = rst;
  assign valid_s[0]  = start & ~busy;
  assign offset_s[0] = offset[OFFSET_BITS-1:0];
  assign value_s[0]  = VW'(offset[OFFSET_BITS-1:0]);
  assign count_s[0]  = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    ccgs_cell #(
      .K  (i + 1),
      .VW (VW),
      .OB (OFFSET_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_s[i]),
      .offset_in (offset_s[i]),
      .value_in  (value_s[i]),
      .count_in  (count_s[i]),
      .valid     (valid_s[i+1]),
      .offset    (offset_s[i+1]),
      .value     (value_s[i+1]),
      .count     (count_s[i+1])
    );
  end

  assign value_ext   = (VW+VALUE_W)'(value_s[STEPS]);
  assign strobe      = valid_s[STEPS];
  assign offset_echo = OFFSET_W'(offset_s[STEPS]);
  assign end_value   = value_ext[VALUE_W-1:0];
  assign odd_count   = (count_s[STEPS] > COUNT_W'(ODD_SAT)) ? ODD_SAT
                                                            : count_s[STEPS][ODD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/ccgs_checker.sv =====
// Port-level assertions for the Collatz sieve, bound to the top level.
`default_nettype none
module ccgs_checker #(
  parameter int STEPS = 61
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          strobe,
  input wire logic [ccgs_pkg::OFFSET_W-1:0] offset_echo,
  input wire logic [ccgs_pkg::ODD_W-1:0]    odd_count
);
  import ccgs_pkg::*;

  logic accepted;
  assign accepted = start & ~busy & ~rst;

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_result_follows_start: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(accepted, STEPS))
    else $error("result without a transaction STEPS cycles earlier");

  a_result_passes_gate: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (odd_count >= GATE_MIN[STEPS-1]))
    else $error("result odd count below last gate");

  a_result_nonzero: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (offset_echo != '0))
    else $error("zero offset survived");

endmodule

bind collatz_coefficient_gate_sieve ccgs_checker #(.STEPS(STEPS)) u_ccgs_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Collatz shortcut sieve with per-step odd-count gates.
`timescale 1ns / 1ps
module tb_top;
  import ccgs_pkg::*;

  localparam int STEPS       = 61;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic [OFFSET_W-1:0] offset;
    logic [VALUE_W-1:0]  value;
    logic [ODD_W-1:0]    odds;
  } survivor_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [OFFSET_W-1:0] offset = '0;
  logic                busy;
  logic                strobe;
  logic [OFFSET_W-1:0] offset_echo;
  logic [VALUE_W-1:0]  end_value;
  logic [ODD_W-1:0]    odd_count;

  int        gate_floor [1:64];
  survivor_t survivors_q [$];
  survivor_t want;
  survivor_t got;
  int        items_taken = 0;
  int        results_seen = 0;
  int        eliminated = 0;
  int        mismatches = 0;
  int        stall_cycles = 0;

  collatz_coefficient_gate_sieve #(
    .STEPS(STEPS),
    .OFFSET_BITS(OFFSET_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .offset(offset),
    .strobe(strobe),
    .offset_echo(offset_echo),
    .end_value(end_value),
    .odd_count(odd_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit run_sieve(input logic [OFFSET_W-1:0] r, output survivor_t res);
    logic [127:0] n;
    int unsigned  odds;
    bit           alive;
    n = 128'(r);
    odds = 0;
    alive = 1'b1;
    for (int k = 1; k <= STEPS && alive; k++) begin
      if (n[0]) begin
        n = n + (n >> 1) + 128'd1;
        odds++;
      end else begin
        n = n >> 1;
      end
      if (odds < gate_floor[k]) alive = 1'b0;
    end
    res.offset = r;
    res.value  = n[VALUE_W-1:0];
    res.odds   = (odds > 63) ? ODD_SAT : odds[ODD_W-1:0];
    return alive;
  endfunction

  function automatic logic [OFFSET_W-1:0] find_survivor();
    logic [OFFSET_W-1:0] r;
    survivor_t           res;
    r = OFFSET_W'($urandom());
    for (int tries = 0; tries < 200000; tries++) begin
      r = OFFSET_W'($urandom());
      if (run_sieve(r, res)) return r;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] exp_v,
                                 input logic [VALUE_W-1:0] act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what, exp_v, act_v);
  endtask

  // hold offset and start until the transaction is taken
  task automatic send_offset(input logic [OFFSET_W-1:0] r);
    start  <= 1'b1;
    offset <= r;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start  <= 1'b0;
      offset <= OFFSET_W'($urandom());
      @(posedge clk);
    end
  endtask

  task automatic test_edge_offsets();
    logic [OFFSET_W-1:0] picks [15];
    picks = '{28'd0, 28'd1, 28'd2, 28'd3, 28'd7, 28'd27, 28'd31, 28'd255,
              28'hFFFFFFF, 28'h7FFFFFF, 28'h8000000, 28'h5555555, 28'hAAAAAAA,
              28'hFFFFFFE, 28'hFFFFFFD};
    foreach (picks[i]) send_offset(picks[i]);
    for (int i = 0; i < 5; i++) send_offset(find_survivor());
  endtask

  task automatic test_random_mix(input int idle_pct, input int count);
    int                  sel;
    logic [OFFSET_W-1:0] r;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 50)
        r = find_survivor();
      else if (sel < 65)
        r = OFFSET_W'($urandom_range(255));
      else if (sel < 75)
        r = {4'hF, 24'($urandom())};
      else
        r = OFFSET_W'($urandom());
      idle_gap(idle_pct);
      send_offset(r);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) begin
        results_seen++;
        got.offset = offset_echo;
        got.value  = end_value;
        got.odds   = odd_count;
        if (survivors_q.size() == 0) begin
          report_mismatch("unexpected result offset_echo", '0, VALUE_W'(got.offset));
        end else begin
          want = survivors_q.pop_front();
          if (got.offset !== want.offset)
            report_mismatch("offset_echo", VALUE_W'(want.offset), VALUE_W'(got.offset));
          if (got.value !== want.value)
            report_mismatch("end_value", want.value, got.value);
          if (got.odds !== want.odds)
            report_mismatch("odd_count", VALUE_W'(want.odds), VALUE_W'(got.odds));
        end
      end
      if (start && !busy) begin
        items_taken++;
        if (run_sieve(offset, want))
          survivors_q.insert(survivors_q.size(), want);
        else
          eliminated++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || strobe)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction", STALL_LIMIT);
      $display("collatz_coefficient_gate_sieve regression: fail");
      $finish;
    end
  end

  initial begin
    logic [127:0] pow3;
    int           q;
    for (int k = 1; k <= 64; k++) begin
      pow3 = 128'd1;
      q = 0;
      while (pow3 < (128'd1 << k)) begin
        pow3 = pow3 * 3;
        q++;
      end
      gate_floor[k] = q;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_edge_offsets();
    test_random_mix(25, 430);
    test_random_mix(70, 430);
    test_random_mix(0, 430);
    start <= 1'b0;
    while (survivors_q.size() != 0) @(posedge clk);
    repeat (STEPS + 8) @(posedge clk);
    $display("sieved %0d offsets: %0d survivors checked, %0d eliminated by a gate",
             items_taken, results_seen, eliminated);
    $display("sender gaps: none, 25%%, 70%%, none; %0d mismatches", mismatches);
    if (mismatches == 0)
      $display("collatz_coefficient_gate_sieve regression: pass");
    else
      $display("collatz_coefficient_gate_sieve regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ccgs_pkg.sv
rtl/core/ccgs_cell.sv
rtl/core/collatz_coefficient_gate_sieve.sv
rtl/core/ccgs_checker.sv
tb/sv/tb_top.sv
